FILE: rtl/core/string_literal_unescape_assert.svh
// Assertion macros for the literal unescape block.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef STRING_LITERAL_UNESCAPE_ASSERT_SVH
`define STRING_LITERAL_UNESCAPE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sle assertion failed");

// Next-cycle implication, disabled during reset.
`define SLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sle assertion failed");

`endif

FILE: rtl/core/sle_pkg.sv
// Shared types, constants and character helpers for the literal unescape block.
// No dependencies.
`default_nettype none

package sle_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CARET_MSK = 8'h3F;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_CARET  = 3'd2,
    MODE_HEX0   = 3'd3,
    MODE_HEX1   = 3'd4,
    MODE_OCT1   = 3'd5,
    MODE_OCT2   = 3'd6
  } mode_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       literal_end;
    logic       run_last;
  } sle_result_t;

  typedef struct packed {
    logic [1:0]  cnt;
    sle_result_t res0;
    sle_result_t res1;
  } sle_push_t;

  function automatic logic is_oct(input logic [7:0] c);
    is_oct = (c >= 8'h30) && (c <= 8'h37);
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    is_dec = (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = is_dec(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    hex_nib = is_dec(c) ? c[3:0] : c[3:0] + 4'd9;
  endfunction

  // single-character escapes; anything not listed passes unchanged
  function automatic logic [7:0] esc_lookup(input logic [7:0] c);
    case (c)
      8'h6E:   esc_lookup = 8'd10;
      8'h74:   esc_lookup = 8'd9;
      8'h62:   esc_lookup = 8'd8;
      8'h72:   esc_lookup = 8'd13;
      8'h66:   esc_lookup = 8'd12;
      8'h65:   esc_lookup = 8'd27;
      8'h20:   esc_lookup = 8'd128;
      8'h23:   esc_lookup = 8'd143;
      8'h2B:   esc_lookup = 8'd129;
      8'h2D:   esc_lookup = 8'd130;
      8'h28:   esc_lookup = 8'd131;
      8'h29:   esc_lookup = 8'd132;
      8'h68:   esc_lookup = 8'd133;
      8'h64:   esc_lookup = 8'd139;
      8'h69:   esc_lookup = 8'd140;
      8'h3E:   esc_lookup = 8'd136;
      8'h3C:   esc_lookup = 8'd135;
      8'h76:   esc_lookup = 8'd138;
      8'h52:   esc_lookup = 8'd134;
      default: esc_lookup = c;
    endcase
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/sle_in_if.sv
// Input channel of the literal unescape block: one raw character per beat.
// No dependencies.
`default_nettype none

interface sle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic [7:0] delimiter;

  modport source (output valid, output ch, output delimiter, input ready);
  modport sink   (input valid, input ch, input delimiter, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sle_out_if.sv
// Result channel of the literal unescape block: one decoded result per beat.
// No dependencies.
`default_nettype none

interface sle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       literal_end;
  logic       run_last;

  modport source (output valid, output out_byte, output has_byte, output literal_end,
                  output run_last, input ready);
  modport sink   (input valid, input out_byte, input has_byte, input literal_end,
                  input run_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sle_decode.sv
// Input register, escape mode state and single-pass decode of one character.
// Depends on sle_pkg, sle_in_if and string_literal_unescape_assert.svh.
`default_nettype none
`include "string_literal_unescape_assert.svh"

module sle_decode (
  input  wire logic              clk,
  input  wire logic              rst_n,
  sle_in_if.sink                 in_chan,
  input  wire logic              room,
  output sle_pkg::sle_push_t     push
);

  logic                 stg_v_r;
  logic [7:0]           ch_r;
  logic [7:0]           delim_r;
  sle_pkg::mode_t       mode_r, mode_nxt;
  logic [7:0]           acc_r, acc_nxt;
  logic                 fire;
  logic                 do_fresh;
  logic [1:0]           n;
  sle_pkg::sle_result_t r0, r1, fr;
  logic                 fr_emit;

  assign fire          = stg_v_r && room;
  assign in_chan.ready = !stg_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      stg_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      ch_r    <= in_chan.ch;
      delim_r <= in_chan.delimiter;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sle_pkg::MODE_NORMAL;
      acc_r  <= '0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    do_fresh = 1'b0;
    n        = 2'd0;
    r0       = '0;
    r1       = '0;
    fr       = '0;
    fr_emit  = 1'b0;

    unique case (mode_r)
      sle_pkg::MODE_ESC: begin
        mode_nxt = sle_pkg::MODE_NORMAL;
        if (ch_r == sle_pkg::CH_CARET) begin
          mode_nxt = sle_pkg::MODE_CARET;
        end else if (ch_r == sle_pkg::CH_X) begin
          acc_nxt  = '0;
          mode_nxt = sle_pkg::MODE_HEX0;
        end else if (sle_pkg::is_oct(ch_r)) begin
          acc_nxt  = {5'd0, ch_r[2:0]};
          mode_nxt = sle_pkg::MODE_OCT1;
        end else begin
          r0 = '{out_byte: sle_pkg::esc_lookup(ch_r), has_byte: 1'b1,
                 literal_end: 1'b0, run_last: 1'b0};
          n  = 2'd1;
        end
      end
      sle_pkg::MODE_CARET: begin
        mode_nxt = sle_pkg::MODE_NORMAL;
        r0 = '{out_byte: ch_r & sle_pkg::CARET_MSK, has_byte: 1'b1,
               literal_end: 1'b0, run_last: 1'b0};
        n  = 2'd1;
      end
      sle_pkg::MODE_HEX0, sle_pkg::MODE_HEX1: begin
        if (sle_pkg::is_hex(ch_r)) begin
          acc_nxt = {acc_r[3:0], sle_pkg::hex_nib(ch_r)};
          if (mode_r == sle_pkg::MODE_HEX0) begin
            mode_nxt = sle_pkg::MODE_HEX1;
          end else begin
            mode_nxt = sle_pkg::MODE_NORMAL;
            r0 = '{out_byte: acc_nxt, has_byte: 1'b1, literal_end: 1'b0, run_last: 1'b0};
            n  = 2'd1;
          end
        end else begin
          r0 = '{out_byte: acc_r, has_byte: 1'b1, literal_end: 1'b0, run_last: 1'b0};
          n  = 2'd1;
          do_fresh = 1'b1;
        end
      end
      sle_pkg::MODE_OCT1, sle_pkg::MODE_OCT2: begin
        if (sle_pkg::is_oct(ch_r)) begin
          acc_nxt = {acc_r[4:0], ch_r[2:0]};
          if (mode_r == sle_pkg::MODE_OCT1) begin
            mode_nxt = sle_pkg::MODE_OCT2;
          end else begin
            mode_nxt = sle_pkg::MODE_NORMAL;
            r0 = '{out_byte: acc_nxt, has_byte: 1'b1, literal_end: 1'b0, run_last: 1'b0};
            n  = 2'd1;
          end
        end else begin
          r0 = '{out_byte: acc_r, has_byte: 1'b1, literal_end: 1'b0, run_last: 1'b0};
          n  = 2'd1;
          do_fresh = 1'b1;
        end
      end
      default: begin
        do_fresh = 1'b1;
      end
    endcase

    // plain character handling, also after a flushed numeric run
    if (do_fresh) begin
      mode_nxt = sle_pkg::MODE_NORMAL;
      if (ch_r == delim_r) begin
        fr      = '{out_byte: 8'd0, has_byte: 1'b0, literal_end: 1'b1, run_last: 1'b0};
        fr_emit = 1'b1;
      end else if (ch_r == sle_pkg::CH_BSLASH) begin
        mode_nxt = sle_pkg::MODE_ESC;
      end else begin
        fr      = '{out_byte: ch_r, has_byte: 1'b1, literal_end: 1'b0, run_last: 1'b0};
        fr_emit = 1'b1;
      end
      if (fr_emit) begin
        if (n == 2'd0) begin
          r0 = fr;
        end else begin
          r1 = fr;
        end
        n = n + 2'd1;
      end
    end

    if (n == 2'd1) begin
      r0.run_last = 1'b1;
    end
    if (n == 2'd2) begin
      r1.run_last = 1'b1;
    end
  end

  assign push.cnt  = fire ? n : 2'd0;
  assign push.res0 = r0;
  assign push.res1 = r1;

  `SLE_ASSERT_NXT(a_stage_hold, clk, rst_n, stg_v_r && !fire, stg_v_r && $stable(ch_r) && $stable(delim_r))
  `SLE_ASSERT_IMP(a_last_one, clk, rst_n, push.cnt == 2'd1, push.res0.run_last)
  `SLE_ASSERT_IMP(a_last_two, clk, rst_n, push.cnt == 2'd2, !push.res0.run_last && push.res1.run_last)

endmodule

`default_nettype wire

FILE: rtl/core/sle_result_fifo.sv
// Result queue: takes up to two results per cycle, delivers one per beat.
// Depends on sle_pkg, sle_out_if and string_literal_unescape_assert.svh.
`default_nettype none
`include "string_literal_unescape_assert.svh"

module sle_result_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sle_pkg::sle_push_t push,
  output logic                   room,
  sle_out_if.source              out_chan
);

  localparam int unsigned PW = sle_pkg::PTR_W;
  localparam int unsigned CW = sle_pkg::CNT_W;

  sle_pkg::sle_result_t mem_r [sle_pkg::FIFO_DEPTH];
  logic [PW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 rd;
  sle_pkg::sle_result_t head;

  assign rd   = out_chan.valid && out_chan.ready;
  assign room = cnt_r <= CW'(sle_pkg::FIFO_DEPTH - 2);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + PW'(rd);
    cnt_nxt    = cnt_r + CW'(push.cnt) - CW'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.res0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[PW'(wr_ptr_r + PW'(1))] <= push.res1;
    end
  end

  assign head                 = mem_r[rd_ptr_r];
  assign out_chan.valid       = cnt_r != '0;
  assign out_chan.out_byte    = head.out_byte;
  assign out_chan.has_byte    = head.has_byte;
  assign out_chan.literal_end = head.literal_end;
  assign out_chan.run_last    = head.run_last;

  `SLE_ASSERT_IMP(a_push_room, clk, rst_n, push.cnt != 2'd0, room && push.cnt != 2'd3)
  `SLE_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(sle_pkg::FIFO_DEPTH))

endmodule

`default_nettype wire

FILE: rtl/core/string_literal_unescape.sv
// Top level of the quoted-literal unescape decoder.
// Depends on sle_pkg, sle_in_if, sle_out_if, sle_decode and sle_result_fifo.
//
// Takes one raw character of a literal body per beat and returns decoded
// results: plain characters, single-character escapes, caret, hex and octal
// escapes, and an end marker when the closing delimiter is seen. A character
// is accepted every cycle as long as the four-entry result queue has room
// for two results; a character can yield two results (a numeric run ended
// by a plain character or the delimiter), and the sustained rate of one
// character per cycle is bounded by one result per cycle at the output. An
// input beat reaches the result port through the input register, then the
// queue write.
`default_nettype none

module string_literal_unescape (
  input  wire logic clk,
  input  wire logic rst_n,
  sle_in_if.sink    in_chan,
  sle_out_if.source out_chan
);

  sle_pkg::sle_push_t push;
  logic               room;

  sle_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .room    (room),
    .push    (push)
  );

  sle_result_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire
